@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ src/b64d_pkg.sv @@
// Shared types, constants and the character classifier of the base64 group decoder.
package b64d_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       is_terminator;
    } t_out_word;

    // One queued job: an optional group of three bytes, then an optional terminator.
    typedef struct packed {
        logic       bytes_vld;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       term;
    } t_job;

    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_PAD   = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    localparam logic [5:0] DIGIT_PLUS  = 6'd62;
    localparam logic [5:0] DIGIT_SLASH = 6'd63;
    localparam logic [1:0] LAST_SLOT   = 2'd3;

    function automatic t_kind char_kind(input logic [7:0] c);
        t_kind k;
        k = KIND_BAD;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F) begin
            k = KIND_DIGIT;
        end else if (c == 8'h3D) begin
            k = KIND_PAD;
        end
        return k;
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            d = {2'b00, DIGIT_PLUS};
        end else if (c == 8'h2F) begin
            d = {2'b00, DIGIT_SLASH};
        end
        return d[5:0];
    endfunction

endpackage

@@ src/b64d_front.sv @@
// Front end: accepts characters, tracks the current group and builds output jobs.
module b64d_front import b64d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [1:0] r_fill, n_fill;
    logic [5:0] r_s0, n_s0;
    logic [5:0] r_s1, n_s1;
    logic [5:0] r_s2, n_s2;
    logic       r_pad2, n_pad2;
    logic       r_inv, n_inv;

    logic       accept;
    t_kind      kind;
    logic [5:0] val;
    logic       inv;
    logic       group_done;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        kind       = char_kind(i_word.text_byte);
        val        = char_value(i_word.text_byte);
        inv        = r_inv || kind == KIND_BAD || (kind == KIND_PAD && r_fill < 2'd2);
        group_done = r_fill == LAST_SLOT;

        n_fill = r_fill;
        n_s0   = r_s0;
        n_s1   = r_s1;
        n_s2   = r_s2;
        n_pad2 = r_pad2;
        n_inv  = r_inv;

        o_job.bytes_vld = group_done && !inv;
        o_job.b0        = {r_s0, r_s1[5:4]};
        o_job.b1        = r_pad2 ? 8'h00 : {r_s1[3:0], r_s2[5:2]};
        if (kind == KIND_PAD) begin
            o_job.b2 = 8'h00;
        end else if (r_pad2) begin
            o_job.b2 = {2'b11, val};
        end else begin
            o_job.b2 = {r_s2[1:0], val};
        end
        o_job.term = i_word.end_of_text;
        o_push     = accept && (o_job.bytes_vld || o_job.term);

        if (accept) begin
            if (group_done || i_word.end_of_text) begin
                // start a fresh group
                n_fill = 2'd0;
                n_s0   = 6'd0;
                n_s1   = 6'd0;
                n_s2   = 6'd0;
                n_pad2 = 1'b0;
                n_inv  = 1'b0;
            end else begin
                n_fill = r_fill + 2'd1;
                n_inv  = inv;
                unique case (r_fill)
                    2'd0:    n_s0 = val;
                    2'd1:    n_s1 = val;
                    default: begin
                        n_s2   = val;
                        n_pad2 = kind == KIND_PAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_s0   <= 6'd0;
            r_s1   <= 6'd0;
            r_s2   <= 6'd0;
            r_pad2 <= 1'b0;
            r_inv  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_s0   <= n_s0;
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_pad2 <= n_pad2;
            r_inv  <= n_inv;
        end
    end

endmodule

@@ src/b64d_queue.sv @@
// Job queue between the front end and the output sequencer.
module b64d_queue import b64d_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full     = r_count == CW'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_job      = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ src/b64d_back.sv @@
// Back end: sends each job's bytes and terminator, one word per unstalled cycle.
module b64d_back import b64d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_nonempty,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic      r_busy;
    t_job      r_cur;
    logic [1:0] r_idx;
    logic      r_out_valid;
    t_out_word r_out_word, n_out_word;

    logic out_free;
    logic step;
    logic last_step;

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        step      = r_busy && out_free;
        last_step = (r_idx == LAST_SLOT) || (r_idx == 2'd2 && !r_cur.term);
        o_pop     = i_q_nonempty && (!r_busy || (step && last_step));

        n_out_word.is_terminator = 1'b0;
        unique case (r_idx)
            2'd0:    n_out_word.decoded_byte = r_cur.b0;
            2'd1:    n_out_word.decoded_byte = r_cur.b1;
            2'd2:    n_out_word.decoded_byte = r_cur.b2;
            default: begin
                n_out_word.decoded_byte  = 8'h00;
                n_out_word.is_terminator = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_job;
        end
        if (step) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                // skip straight to the terminator slot when the group gave nothing
                r_idx  <= i_q_job.bytes_vld ? 2'd0 : LAST_SLOT;
            end else if (step && last_step) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_idx <= r_idx + 2'd1;
            end

            if (step) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/base64_group_decoder.sv @@
// Base64 group decoder. One text character is taken per clock cycle while not stalled;
// each character is classified and folded into the current group of four by the front
// end with no stall of its own. A complete valid group becomes three output words, and
// the character flagged end_of_text adds a closing terminator word (decoded_byte 0,
// is_terminator 1) after any bytes of that group; a trailing partial group is dropped.
// Results leave at one word per cycle from the output sequencer while i_stall is low, so
// a group gives three output words and a terminator one more. A job queue of QUEUE_DEPTH
// entries sits between the two: input is stalled only while that queue is full, which
// for ordinary text (four characters in, three bytes out) happens only on output stalls.
// A group's first word passes the queue, current-job and output registers in turn.
module base64_group_decoder import b64d_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic q_full;
    logic q_nonempty;
    logic q_push;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_job      (push_job),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_job      (head_job)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_job      (head_job),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word       (o_word)
    );

endmodule

@@ src/b64d_checker.sv @@
// Port-level checks of the base64 group decoder, bound to the top level.
`include "assert_macros.svh"

module b64d_checker import b64d_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_word  i_word,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_word
);

    // hold a stalled input word
    `ASSERT_CLKD(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_word))

    // hold a stalled result word
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_word))

    // the terminator carries a zero byte
    `ASSERT_CLKD(a_term_zero, i_clk, i_rst_n, o_valid && o_word.is_terminator |-> o_word.decoded_byte == 8'h00)

    // drop any result while in reset
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind base64_group_decoder b64d_checker u_b64d_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the base64 group decoder: directed groups, then random text.
`timescale 1ns / 1ps

module tb;
    import b64d_pkg::*;

    localparam logic [7:0] PAD_CHAR    = "=";
    localparam int         STUCK_LIMIT = 1000;
    localparam int         END_WAIT    = 16;
    localparam int         HOLD_CYCLES = 80;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    // Group state as the decoder should hold it
    logic [1:0] grp_fill       = '0;
    logic [5:0] grp_digits [3] = '{default: '0};
    logic [2:0] grp_pads       = '0;
    logic       grp_bad        = 1'b0;

    t_out_word pending_bytes[$];
    int        errors        = 0;
    int        stuck_cycles  = 0;
    int        rx_hold_len   = 0;
    int        tx_burst_left = 0;
    bit        tx_gaps_on    = 1'b0;

    base64_group_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_kind classify_char(input logic [7:0] c, output logic [5:0] digit);
        digit = '0;
        if (c >= "A" && c <= "Z") begin
            digit = 6'(c - "A");
            return KIND_DIGIT;
        end
        if (c >= "a" && c <= "z") begin
            digit = 6'(c - "a" + 26);
            return KIND_DIGIT;
        end
        if (c >= "0" && c <= "9") begin
            digit = 6'(c - "0" + 52);
            return KIND_DIGIT;
        end
        if (c == "+") begin
            digit = DIGIT_PLUS;
            return KIND_DIGIT;
        end
        if (c == "/") begin
            digit = DIGIT_SLASH;
            return KIND_DIGIT;
        end
        if (c == PAD_CHAR) begin
            return KIND_PAD;
        end
        return KIND_BAD;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] d);
        if (d < 26) return 8'("A" + d);
        if (d < 52) return 8'("a" + d - 26);
        if (d < 62) return 8'("0" + d - 52);
        if (d == DIGIT_PLUS) return "+";
        return "/";
    endfunction

    task automatic clear_group();
        grp_fill = '0;
        grp_digits = '{default: '0};
        grp_pads = '0;
        grp_bad = 1'b0;
    endtask

    // Fold one accepted character into the group and queue the bytes and terminator it releases
    task automatic queue_decoded(input t_in_word w);
        t_kind      kind;
        logic [5:0] digit;
        t_out_word  ow;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        kind = classify_char(w.text_byte, digit);
        if (kind == KIND_BAD || (kind == KIND_PAD && grp_fill < 2)) begin
            grp_bad = 1'b1;
        end
        if (grp_fill != LAST_SLOT) begin
            if (kind == KIND_DIGIT) begin
                grp_digits[grp_fill] = digit;
            end else if (kind == KIND_PAD) begin
                grp_pads[grp_fill] = 1'b1;
            end
            grp_fill = grp_fill + 2'd1;
        end else begin
            if (!grp_bad) begin
                b0 = {grp_digits[0], grp_digits[1][5:4]};
                b1 = grp_pads[2] ? 8'h00 : {grp_digits[1][3:0], grp_digits[2][5:2]};
                if (kind == KIND_PAD) begin
                    b2 = 8'h00;
                end else if (grp_pads[2]) begin
                    b2 = {2'b11, digit};
                end else begin
                    b2 = {grp_digits[2][1:0], digit};
                end
                ow.is_terminator = 1'b0;
                ow.decoded_byte = b0;
                pending_bytes.push_back(ow);
                ow.decoded_byte = b1;
                pending_bytes.push_back(ow);
                ow.decoded_byte = b2;
                pending_bytes.push_back(ow);
            end
            clear_group();
        end
        if (w.end_of_text) begin
            ow.decoded_byte = 8'h00;
            ow.is_terminator = 1'b1;
            pending_bytes.push_back(ow);
            clear_group();
        end
    endtask

    // Sample both handshakes mid-cycle, where every signal has settled
    always @(negedge i_clk) begin
        t_out_word want;
        bit        in_fire;
        bit        out_fire;
        if (i_rst_n) begin
            in_fire = i_valid && !o_stall;
            out_fire = o_valid && !i_stall;
            if (in_fire) begin
                queue_decoded(i_word);
            end
            if (out_fire) begin
                if (pending_bytes.size() == 0) begin
                    $display("%0t: expected no word, got byte %02h term %0b",
                             $time, o_word.decoded_byte, o_word.is_terminator);
                    errors++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_word.decoded_byte !== want.decoded_byte) begin
                        $display("%0t: decoded_byte expected %02h, got %02h",
                                 $time, want.decoded_byte, o_word.decoded_byte);
                        errors++;
                    end
                    if (o_word.is_terminator !== want.is_terminator) begin
                        $display("%0t: is_terminator expected %0b, got %0b",
                                 $time, want.is_terminator, o_word.is_terminator);
                        errors++;
                    end
                end
            end
            stuck_cycles = (in_fire || out_fire) ? 0 : stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall segments, plus a long hold when one is requested
    initial begin
        int pct;
        int seg_left;
        i_stall = 1'b0;
        pct = 0;
        seg_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                i_stall <= 1'b1;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                i_stall <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 48);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 20;
                        2: pct = 50;
                        default: pct = 80;
                    endcase
                end
                seg_left--;
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eot);
        bit taken;
        int gap;
        i_word <= '{text_byte: c, end_of_text: eot};
        i_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                tx_burst_left--;
            end
        end
    endtask

    task automatic send_text(input string s, input bit eot_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    // Mostly well-formed groups; some padding, some noise, text ends now and then
    task automatic send_random_text(input int n_chars);
        int         r;
        logic [7:0] c;
        logic       eot;
        for (int i = 0; i < n_chars; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                c = 8'($urandom_range(0, 255));
            end else if (r < 8 || (grp_fill >= 2 && r < 24)) begin
                c = PAD_CHAR;
            end else begin
                c = sextet_char(6'($urandom_range(0, 63)));
            end
            if (grp_fill == LAST_SLOT) begin
                eot = ($urandom_range(0, 9) == 0);
            end else begin
                eot = ($urandom_range(0, 39) == 0);
            end
            send_char(c, eot || (i == n_chars - 1));
        end
    endtask

    task automatic wait_for_drain();
        if (i_valid) begin
            i_valid <= 1'b0;
        end
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_digit_ranges();
        tx_gaps_on = 1'b0;
        send_text("AZ09", 1'b0);
        send_text("az+/", 1'b0);
    endtask

    task automatic test_padding();
        send_text("TQ=/", 1'b0);
        send_text("TQ==", 1'b1);
    endtask

    task automatic test_rejected_groups();
        send_char("A", 1'b0);
        send_char(PAD_CHAR, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("=AAA", 1'b0);
    endtask

    task automatic test_trailing_partial();
        send_text("AB", 1'b1);
        send_text("Q", 1'b1);
    endtask

    task automatic test_random_stream();
        tx_gaps_on = 1'b1;
        send_random_text(150);
    endtask

    // Hold the output long enough for the job queue to fill and stall input
    task automatic test_receiver_holdoff();
        tx_gaps_on = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        send_random_text(48);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_random_text(24);
        wait_for_drain();
        send_random_text(24);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_digit_ranges();
        test_padding();
        test_rejected_groups();
        test_trailing_partial();
        test_random_stream();
        test_receiver_holdoff();
        test_sender_pause();

        wait_for_drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_bytes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_group_decoder.sv
src/b64d_checker.sv
test/tb.sv
